@@ rtl/core/round_robin_slot_scheduler_unit_defines.svh @@
// Assertion macros shared by the scheduler RTL files
`ifndef ROUND_ROBIN_SLOT_SCHEDULER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_SLOT_SCHEDULER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property at every rising edge outside reset
`define RRSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a plain condition at every rising edge outside reset
`define RRSS_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define RRSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define RRSS_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`endif

`endif

@@ rtl/core/rrss_pkg.sv @@
// Shared types and constants of the round-robin slot scheduler
`default_nettype none

package rrss_pkg;

    localparam int CMD_W      = 2;
    localparam int TIME_W     = 64;
    localparam int ID_W       = 32;
    localparam int SLOT_OUT_W = 3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXIT   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SLEEP  = 2'd3;

    // Slot states
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_SLEEP = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic latch_before;
        logic cscan_init;
        logic sched_init;
        logic do_sleep;
        logic exit_free;
        logic exit_parent;
        logic scan_step;
        logic cscan_step;
        logic load_result;
    } rrss_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             runner;
        logic             live_zero;
        logic             scan_done;
        logic             cscan_done;
        logic             out_free;
    } rrss_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/rrss_ctrl.sv @@
// Sequencer of the scheduler: steps each command through its phases
`default_nettype none
`include "round_robin_slot_scheduler_unit_defines.svh"

module rrss_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rrss_pkg::rrss_stat_t stat,
    output rrss_pkg::rrss_cmd_t    cmd
);
    import rrss_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SLEEP  = 4'd2;
    localparam logic [3:0] S_EXIT_A = 4'd3;
    localparam logic [3:0] S_EXIT_B = 4'd4;
    localparam logic [3:0] S_SCHED  = 4'd5;
    localparam logic [3:0] S_SCAN   = 4'd6;
    localparam logic [3:0] S_CSCAN  = 4'd7;
    localparam logic [3:0] S_IDRD   = 4'd8;
    localparam logic [3:0] S_RESULT = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    // Decode state into next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.latch_before = 1'b1;
                unique case (stat.command)
                    CMD_CREATE: begin
                        cmd.cscan_init = 1'b1;
                        state_next     = S_CSCAN;
                    end
                    CMD_TICK: begin
                        cmd.sched_init = 1'b1;
                        state_next     = stat.live_zero ? S_IDRD : S_SCAN;
                    end
                    CMD_EXIT: begin
                        state_next = stat.runner ? S_EXIT_A : S_IDRD;
                    end
                    default: begin
                        state_next = stat.runner ? S_SLEEP : S_IDRD;
                    end
                endcase
            end
            S_SLEEP: begin
                cmd.do_sleep = 1'b1;
                state_next   = S_SCHED;
            end
            S_EXIT_A: begin
                cmd.exit_free = 1'b1;
                state_next    = S_EXIT_B;
            end
            S_EXIT_B: begin
                cmd.exit_parent = 1'b1;
                state_next      = S_SCHED;
            end
            S_SCHED: begin
                cmd.sched_init = 1'b1;
                state_next     = stat.live_zero ? S_IDRD : S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_IDRD;
                end
            end
            S_CSCAN: begin
                cmd.cscan_step = 1'b1;
                if (stat.cscan_done) begin
                    state_next = S_IDRD;
                end
            end
            S_IDRD: begin
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `RRSS_ASSERT(a_accept_decodes, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == S_DECODE), "transfer not followed by decode")
    `RRSS_ASSERT(a_scan_exit, aclk, aresetn, (state_reg == S_SCAN) |=> (state_reg == S_SCAN || state_reg == S_IDRD), "scan left to wrong state")

endmodule

`default_nettype wire

@@ rtl/core/rrss_dpath.sv @@
// Scheduler datapath: slot table, wake/id/parent memories, scan and result
`default_nettype none
`include "round_robin_slot_scheduler_unit_defines.svh"

module rrss_dpath #(
    parameter int NUM_SLOTS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rrss_pkg::rrss_cmd_t           cmd,
    output rrss_pkg::rrss_stat_t               stat,
    input  wire logic [rrss_pkg::CMD_W-1:0]    s_command,
    input  wire logic [rrss_pkg::TIME_W-1:0]   s_now,
    input  wire logic [rrss_pkg::TIME_W-1:0]   s_wakeup_at,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [rrss_pkg::SLOT_OUT_W-1:0]    m_slot,
    output logic [rrss_pkg::ID_W-1:0]          m_task_id,
    output logic                               m_ok,
    output logic                               m_idle,
    output logic                               m_switched
);
    import rrss_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        slot_inc = (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    // Slot table and memories
    logic [1:0]        slot_state_reg  [NUM_SLOTS];
    logic [1:0]        slot_state_next [NUM_SLOTS];
    logic [TIME_W-1:0] wake_mem        [NUM_SLOTS];
    logic [ID_W-1:0]   id_mem          [NUM_SLOTS];
    logic [SW:0]       parent_mem      [NUM_SLOTS];

    // Control registers
    logic [SW-1:0]   cur_reg, cur_next;
    logic            cv_reg, cv_next;
    logic            idle_reg, idle_next;
    logic [CW-1:0]   live_reg, live_next;
    logic [ID_W-1:0] next_id_reg, next_id_next;
    logic            m_valid_reg, m_valid_next;

    // Payload registers
    logic [CMD_W-1:0]      cmd_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [TIME_W-1:0]     wake_in_reg;
    logic                  before_valid_reg;
    logic [SW-1:0]         before_slot_reg;
    logic                  ok_reg;
    logic [SW-1:0]         start_reg;
    logic [SW-1:0]         scan_reg, scan_next;
    logic [SW-1:0]         res_slot_reg;
    logic [ID_W-1:0]       res_id_reg;
    logic [TIME_W-1:0]     wake_q;
    logic [ID_W-1:0]       id_q;
    logic [SW:0]           parent_q;
    logic [SLOT_OUT_W-1:0] m_slot_reg;
    logic [ID_W-1:0]       m_task_id_reg;
    logic                  m_ok_reg;
    logic                  m_idle_reg;
    logic                  m_switched_reg;

    logic          runner;
    logic [1:0]    scan_st;
    logic          scan_hit;
    logic          scan_wrap;
    logic          scan_done;
    logic          cscan_hit;
    logic          cscan_done;
    logic [SW-1:0] sched_start;
    logic [SW-1:0] parent_sl;
    logic          is_create;
    logic          out_free;

    // Derive runner and scan decisions
    assign runner      = cv_reg && !idle_reg && (slot_state_reg[cur_reg] == ST_RUN);
    assign scan_st     = slot_state_reg[scan_reg];
    assign scan_hit    = (scan_st == ST_READY) || ((scan_st == ST_SLEEP) && (wake_q <= now_reg));
    assign scan_wrap   = (scan_reg == start_reg);
    assign scan_done   = scan_hit || scan_wrap;
    assign cscan_hit   = !(cv_reg && (scan_reg == cur_reg)) && (scan_st == ST_FREE);
    assign cscan_done  = cscan_hit || (scan_reg == LAST_SLOT);
    assign sched_start = cv_reg ? cur_reg : '0;
    assign parent_sl   = parent_q[SW-1:0];
    assign is_create   = (cmd_reg == CMD_CREATE);
    assign out_free    = !m_valid_reg || m_ready;

    assign stat.command    = cmd_reg;
    assign stat.runner     = runner;
    assign stat.live_zero  = (live_reg == '0);
    assign stat.scan_done  = scan_done;
    assign stat.cscan_done = cscan_done;
    assign stat.out_free   = out_free;

    // Update slot states
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_state_next[i] = slot_state_reg[i];
        end
        if (cmd.do_sleep) begin
            slot_state_next[cur_reg] = ST_SLEEP;
        end
        if (cmd.exit_free) begin
            slot_state_next[cur_reg] = ST_FREE;
        end
        if (cmd.exit_parent && parent_q[SW] && (slot_state_reg[parent_sl] == ST_SLEEP)) begin
            slot_state_next[parent_sl] = ST_READY;
        end
        if (cmd.cscan_step && cscan_hit) begin
            slot_state_next[scan_reg] = ST_READY;
        end
        if (cmd.scan_step && scan_hit) begin
            // demote the previous runner, then run the pick
            if (runner && (cur_reg != scan_reg)) begin
                slot_state_next[cur_reg] = ST_READY;
            end
            slot_state_next[scan_reg] = ST_RUN;
        end
    end

    // Compute control register updates
    always_comb begin
        cur_next     = cur_reg;
        cv_next      = cv_reg;
        idle_next    = idle_reg;
        live_next    = live_reg;
        next_id_next = next_id_reg;
        m_valid_next = m_valid_reg;
        if (cmd.sched_init && (live_reg == '0)) begin
            idle_next = 1'b1;
        end
        if (cmd.exit_free && (live_reg != '0)) begin
            live_next = live_reg - 1'b1;
        end
        if (cmd.cscan_step && cscan_hit) begin
            live_next    = live_reg + 1'b1;
            next_id_next = next_id_reg + 1'b1;
        end
        if (cmd.scan_step && scan_done) begin
            cur_next  = scan_reg;
            cv_next   = 1'b1;
            idle_next = !(scan_hit || (scan_st == ST_RUN));
        end
        if (cmd.load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Step the scan position
    always_comb begin
        scan_next = scan_reg;
        if (cmd.sched_init) begin
            scan_next = slot_inc(sched_start);
        end else if (cmd.cscan_init) begin
            scan_next = '0;
        end else if ((cmd.scan_step && !scan_done) || (cmd.cscan_step && !cscan_done)) begin
            scan_next = slot_inc(scan_reg);
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_state_reg[i] <= ST_FREE;
            end
            cur_reg     <= '0;
            cv_reg      <= 1'b0;
            idle_reg    <= 1'b1;
            live_reg    <= '0;
            next_id_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_state_reg[i] <= slot_state_next[i];
            end
            cur_reg     <= cur_next;
            cv_reg      <= cv_next;
            idle_reg    <= idle_next;
            live_reg    <= live_next;
            next_id_reg <= next_id_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the transfer and per-command values
    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
        if (cmd.capture) begin
            cmd_reg     <= s_command;
            now_reg     <= s_now;
            wake_in_reg <= s_wakeup_at;
        end
        if (cmd.latch_before) begin
            before_valid_reg <= runner;
            before_slot_reg  <= cur_reg;
            ok_reg           <= (cmd_reg == CMD_TICK) ? (live_reg != '0) : runner;
        end
        if (cmd.sched_init) begin
            start_reg <= sched_start;
        end
        if (cmd.cscan_step && cscan_done) begin
            res_slot_reg <= cscan_hit ? scan_reg : '0;
            res_id_reg   <= cscan_hit ? next_id_reg : '0;
            ok_reg       <= cscan_hit;
        end
    end

    // Write and read the wake, id and parent memories
    always_ff @(posedge aclk) begin
        if (cmd.do_sleep) begin
            wake_mem[cur_reg] <= wake_in_reg;
        end
        if (cmd.cscan_step && cscan_hit) begin
            id_mem[scan_reg]     <= next_id_reg;
            parent_mem[scan_reg] <= before_valid_reg ? {1'b1, before_slot_reg} : '0;
        end else if (cmd.exit_parent) begin
            parent_mem[cur_reg] <= '0;
        end
        wake_q   <= wake_mem[scan_next];
        id_q     <= id_mem[cur_reg];
        parent_q <= parent_mem[cur_reg];
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            m_ok_reg   <= ok_reg;
            m_idle_reg <= !runner;
            if (is_create) begin
                m_slot_reg     <= SLOT_OUT_W'(res_slot_reg);
                m_task_id_reg  <= res_id_reg;
                m_switched_reg <= 1'b0;
            end else begin
                m_slot_reg     <= runner ? SLOT_OUT_W'(cur_reg) : '0;
                m_task_id_reg  <= runner ? id_q : '0;
                m_switched_reg <= (before_valid_reg != runner) ||
                                  (before_valid_reg && runner && (before_slot_reg != cur_reg));
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_slot     = m_slot_reg;
    assign m_task_id  = m_task_id_reg;
    assign m_ok       = m_ok_reg;
    assign m_idle     = m_idle_reg;
    assign m_switched = m_switched_reg;

    // Gather per-slot flags for the checks below
    logic [NUM_SLOTS-1:0] run_vec;
    logic [NUM_SLOTS-1:0] used_vec;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            run_vec[i]  = (slot_state_reg[i] == ST_RUN);
            used_vec[i] = (slot_state_reg[i] != ST_FREE);
        end
    end

    `RRSS_ASSERT_ALWAYS(a_one_runner, aclk, aresetn, $countones(run_vec) <= 1, "more than one running slot")
    `RRSS_ASSERT_ALWAYS(a_live_count, aclk, aresetn, $countones(used_vec) == int'(live_reg), "live count out of step with slot table")

endmodule

`default_nettype wire

@@ rtl/core/round_robin_slot_scheduler_unit.sv @@
// Top level of the round-robin slot scheduler with sleep timers
//
// One command is taken per transfer and gives exactly one result transfer.
// Commands are handled one at a time; the next transfer is taken as soon as
// the previous result sits in the output register. From transfer to result,
// a tick runs the slot scan; sleep first puts the runner to sleep, exit first
// frees its slot and wakes a sleeping parent, and both then run the scan; create
// runs its own scan for a free slot. The slot scan visits one slot per cycle and
// reads one wake time per cycle from the wake-time memory, and a registered read
// of the task-id memory follows it. Exit or sleep with no running task, a tick on
// an empty table and an exit that empties the table skip the scan. A result that
// waits for the receiver holds back the result of the next command.
// No clearing pass is needed after reset: the slot states reset to free, and
// the wake, id and parent memories are only read after being written.
`default_nettype none

module round_robin_slot_scheduler_unit #(
    parameter int NUM_SLOTS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [rrss_pkg::CMD_W-1:0]    s_command,
    input  wire logic [rrss_pkg::TIME_W-1:0]   s_now,
    input  wire logic [rrss_pkg::TIME_W-1:0]   s_wakeup_at,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [rrss_pkg::SLOT_OUT_W-1:0]    m_slot,
    output logic [rrss_pkg::ID_W-1:0]          m_task_id,
    output logic                               m_ok,
    output logic                               m_idle,
    output logic                               m_switched
);
    import rrss_pkg::*;

    rrss_cmd_t  cmd;
    rrss_stat_t stat;

    // Sequence the command phases
    rrss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Hold the slot table and produce the result
    rrss_dpath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_command   (s_command),
        .s_now       (s_now),
        .s_wakeup_at (s_wakeup_at),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_slot      (m_slot),
        .m_task_id   (m_task_id),
        .m_ok        (m_ok),
        .m_idle      (m_idle),
        .m_switched  (m_switched)
    );

endmodule

`default_nettype wire
